FILE: sv/dapm_pkg.sv
// Shared types and constants for the delta approximate pattern matcher.
// Used by delta_approximate_pattern_match; depends on nothing.
`timescale 1ns / 1ps

package dapm_pkg;

  // Default sizes handed to the top level
  localparam int PATTERN_MAX_DEFAULT   = 32;
  localparam int POSITION_BITS_DEFAULT = 32;

  // Fixed field and register widths
  localparam int PATTERN_REGS  = 4;   // 64-bit pattern registers
  localparam int CFG_DATA_W    = 64;
  localparam int CFG_INDEX_W   = 3;
  localparam int LENGTH_BITS   = 6;
  localparam int DELTA_BITS    = 8;
  localparam int START_W       = 32;
  localparam int LENGTH_RESET  = 1;

  // Register map
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_PATTERN_0      = 3'd0,
    REG_PATTERN_1      = 3'd1,
    REG_PATTERN_2      = 3'd2,
    REG_PATTERN_3      = 3'd3,
    REG_PATTERN_LENGTH = 3'd4,
    REG_MAX_DIFFERENCE = 3'd5
  } cfg_index_t;

  // One text transfer
  typedef struct packed {
    logic [7:0] text_byte;
    logic       end_of_text;
  } text_item_t;

  // One result transfer
  typedef struct packed {
    logic               match_found;
    logic [START_W-1:0] match_start;
  } result_item_t;

endpackage

FILE: sv/delta_approximate_pattern_match.sv
// Delta approximate pattern matcher: each text transfer yields one registered result.
// Throughput one text byte per cycle while text_stall is low; all pattern lanes are
// compared in parallel with the shifted window; a full two-entry result buffer stalls text.
// Synchronous active-high reset: pattern 0, length 1, delta 0, window/count/position clear.
// Depends on dapm_pkg.
`timescale 1ns / 1ps

module delta_approximate_pattern_match #(
  parameter int PATTERN_MAX   = dapm_pkg::PATTERN_MAX_DEFAULT,
  parameter int POSITION_BITS = dapm_pkg::POSITION_BITS_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst,
  // text channel
  input  logic                              text_valid,
  output logic                              text_stall,
  input  dapm_pkg::text_item_t              text,
  // result channel
  output logic                              result_valid,
  input  logic                              result_stall,
  output dapm_pkg::result_item_t            result,
  // configuration write channel
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  dapm_pkg::cfg_index_t              cfg_index,
  input  logic [dapm_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import dapm_pkg::*;

  localparam int LEN_W = $clog2(PATTERN_MAX + 1);
  localparam int IDX_W = $clog2(PATTERN_MAX);
  localparam int CMP_W = (LEN_W > LENGTH_BITS) ? LEN_W : LENGTH_BITS;

  // Configuration registers
  logic [CFG_DATA_W-1:0]  pattern_regs [PATTERN_REGS];
  logic [LENGTH_BITS-1:0] pattern_length;
  logic [DELTA_BITS-1:0]  max_difference;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int r = 0; r < PATTERN_REGS; r++) begin
        pattern_regs[r] <= '0;
      end
      pattern_length <= LENGTH_BITS'(LENGTH_RESET);
      max_difference <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_PATTERN_0:      pattern_regs[0] <= cfg_data;
        REG_PATTERN_1:      pattern_regs[1] <= cfg_data;
        REG_PATTERN_2:      pattern_regs[2] <= cfg_data;
        REG_PATTERN_3:      pattern_regs[3] <= cfg_data;
        REG_PATTERN_LENGTH: pattern_length <= cfg_data[LENGTH_BITS-1:0];
        REG_MAX_DIFFERENCE: max_difference <= cfg_data[DELTA_BITS-1:0];
        default: ;  // writes outside the map are dropped
      endcase
    end
  end

  // Pattern bytes by index; bytes past the registers read as zero
  logic [7:0] pbyte [PATTERN_MAX];

  for (genvar g = 0; g < PATTERN_MAX; g++) begin : g_pbyte
    if (g < PATTERN_REGS * 8) begin : g_reg
      localparam int R = g / 8;
      localparam int B = (g % 8) * 8;
      assign pbyte[g] = pattern_regs[R][B +: 8];
    end else begin : g_zero
      assign pbyte[g] = 8'd0;
    end
  end

  // Effective length, saturated to the window depth
  logic [CMP_W-1:0] len_ext;
  logic [LEN_W-1:0] len_eff;

  assign len_ext = CMP_W'(pattern_length);
  assign len_eff = (len_ext > CMP_W'(PATTERN_MAX)) ? LEN_W'(PATTERN_MAX)
                                                   : LEN_W'(len_ext);

  // Text state
  logic [7:0]               window [PATTERN_MAX];
  logic [LEN_W-1:0]         bytes_seen;
  logic [POSITION_BITS-1:0] text_position;

  logic             text_xfer;
  logic [7:0]       win_new [PATTERN_MAX];
  logic [LEN_W-1:0] bytes_seen_next;

  assign win_new[0] = text.text_byte;
  for (genvar k = 1; k < PATTERN_MAX; k++) begin : g_shift
    assign win_new[k] = window[k-1];
  end

  assign bytes_seen_next = (bytes_seen < LEN_W'(PATTERN_MAX)) ? bytes_seen + LEN_W'(1)
                                                               : bytes_seen;

  // Per-lane compare: window lane k meets pattern byte len-1-k
  logic [PATTERN_MAX-1:0] lane_ok;

  for (genvar k = 0; k < PATTERN_MAX; k++) begin : g_lane
    logic [LEN_W-1:0] lane_idx;
    logic             lane_on;
    logic [7:0]       p_byte;
    logic [8:0]       diff;
    logic [8:0]       abs_diff;

    assign lane_on  = LEN_W'(k) < len_eff;
    assign lane_idx = len_eff - LEN_W'(1) - LEN_W'(k);
    assign p_byte   = pbyte[lane_idx[IDX_W-1:0]];
    assign diff     = {1'b0, p_byte} - {1'b0, win_new[k]};
    assign abs_diff = diff[8] ? (9'd0 - diff) : diff;
    assign lane_ok[k] = !lane_on || (abs_diff <= {1'b0, max_difference});
  end

  logic                      found;
  logic [POSITION_BITS-1:0]  start_pos;
  logic [POSITION_BITS+START_W-1:0] start_ext;
  result_item_t              res_new;

  assign found     = (len_eff != '0) && (bytes_seen_next >= len_eff) && (&lane_ok);
  assign start_pos = text_position - POSITION_BITS'(len_eff) + POSITION_BITS'(1);
  assign start_ext = {{START_W{1'b0}}, start_pos};

  assign res_new.match_found = found;
  assign res_new.match_start = found ? start_ext[START_W-1:0] : '0;

  // Window, count and position update on each text transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < PATTERN_MAX; i++) begin
        window[i] <= '0;
      end
      bytes_seen    <= '0;
      text_position <= '0;
    end else if (text_xfer) begin
      if (text.end_of_text) begin
        for (int i = 0; i < PATTERN_MAX; i++) begin
          window[i] <= '0;
        end
        bytes_seen    <= '0;
        text_position <= '0;
      end else begin
        for (int i = 0; i < PATTERN_MAX; i++) begin
          window[i] <= win_new[i];
        end
        bytes_seen <= bytes_seen_next;
        if (text_position != {POSITION_BITS{1'b1}}) begin
          text_position <= text_position + POSITION_BITS'(1);
        end
      end
    end
  end

  // Two-entry result buffer: output register plus skid entry
  logic         out_valid;
  logic         skid_valid;
  result_item_t out_item;
  result_item_t skid_item;
  logic         out_xfer;

  assign text_stall   = skid_valid;
  assign text_xfer    = text_valid && !text_stall;
  assign out_xfer     = out_valid && !result_stall;
  assign result_valid = out_valid;
  assign result       = out_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (skid_valid) begin
        // no transfer in while the skid entry is full
        if (out_xfer) begin
          out_valid  <= 1'b1;
          skid_valid <= 1'b0;
        end
      end else if (text_xfer) begin
        if (out_valid && result_stall) begin
          skid_valid <= 1'b1;
        end else begin
          out_valid <= 1'b1;
        end
      end else if (out_xfer) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (out_xfer) begin
        out_item <= skid_item;
      end
    end else if (text_xfer) begin
      if (out_valid && result_stall) begin
        skid_item <= res_new;
      end else begin
        out_item <= res_new;
      end
    end
  end

endmodule

FILE: tb/tb.sv
// Self-checking testbench for delta_approximate_pattern_match.
// Streams text bytes under random pacing and compares every result transfer
// against an in-bench predictor. Depends on dapm_pkg and the matcher RTL.
`timescale 1ns / 1ps

module tb;
  import dapm_pkg::*;

  localparam int WINDOW       = PATTERN_MAX_DEFAULT;
  localparam int POS_W        = POSITION_BITS_DEFAULT;
  localparam int TARGET_ITEMS = 1250;
  localparam int IDLE_LIMIT   = 2000;
  localparam int LONG_HOLD    = 80;
  localparam int DRAIN_CYCLES = 4;

  // Predicts match results from accepted text transfers and checks the results
  class match_scoreboard;
    logic [CFG_DATA_W-1:0]  pattern_words [PATTERN_REGS];
    logic [LENGTH_BITS-1:0] pattern_len;
    logic [DELTA_BITS-1:0]  delta;
    logic [7:0]             window [WINDOW];
    int unsigned            seen;
    logic [POS_W-1:0]       position;
    result_item_t           match_q [$];
    int unsigned            errors;

    function new();
      foreach (pattern_words[i]) pattern_words[i] = '0;
      pattern_len = LENGTH_BITS'(LENGTH_RESET);
      delta       = '0;
      errors      = 0;
      clear_text();
    endfunction

    function void clear_text();
      foreach (window[i]) window[i] = '0;
      seen     = 0;
      position = '0;
    endfunction

    function void write_reg(cfg_index_t idx, logic [CFG_DATA_W-1:0] value);
      case (idx)
        REG_PATTERN_0, REG_PATTERN_1, REG_PATTERN_2, REG_PATTERN_3: begin
          pattern_words[int'(idx)] = value;
        end
        REG_PATTERN_LENGTH: pattern_len = value[LENGTH_BITS-1:0];
        REG_MAX_DIFFERENCE: delta = value[DELTA_BITS-1:0];
        default: ;
      endcase
    endfunction

    function int unsigned pending();
      return match_q.size();
    endfunction

    // Shift in the byte, test the one alignment ending here, then advance
    function void note_text(text_item_t it);
      result_item_t want;
      int           len;
      int           p;
      int           t;
      int           d;
      bit           hit;
      for (int i = WINDOW - 1; i > 0; i--) window[i] = window[i-1];
      window[0] = it.text_byte;
      if (seen < WINDOW) seen++;
      len  = (int'(pattern_len) > WINDOW) ? WINDOW : int'(pattern_len);
      want = '0;
      if (len > 0 && seen >= len) begin
        hit = 1'b1;
        for (int i = 0; i < len; i++) begin
          p = int'(pattern_words[i / 8][(i % 8) * 8 +: 8]);
          t = int'(window[len - 1 - i]);
          d = (p > t) ? p - t : t - p;
          if (d > int'(delta)) hit = 1'b0;
        end
        if (hit) begin
          want.match_found = 1'b1;
          want.match_start = START_W'(position - POS_W'(len - 1));
        end
      end
      match_q.push_back(want);
      // end of text clears; otherwise the position saturates at its top
      if (it.end_of_text) clear_text();
      else if (position != '1) position++;
    endfunction

    function void check_result(result_item_t got);
      result_item_t want;
      if (match_q.size() == 0) begin
        $error("result transfer with nothing outstanding: found %0d start %0d",
               got.match_found, got.match_start);
        errors++;
        return;
      end
      want = match_q.pop_front();
      if (got.match_found !== want.match_found) begin
        $error("match_found: expected %0d, actual %0d", want.match_found, got.match_found);
        errors++;
      end
      if (got.match_start !== want.match_start) begin
        $error("match_start: expected %0d, actual %0d", want.match_start, got.match_start);
        errors++;
      end
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  text_valid;
  logic                  text_stall;
  text_item_t            text;
  logic                  result_valid;
  logic                  result_stall;
  result_item_t          result;
  logic                  cfg_valid;
  logic                  cfg_ready;
  cfg_index_t            cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  match_scoreboard sb;

  // Driver-side copy of the settings, used to shape the text
  logic [CFG_DATA_W-1:0] cur_pattern [PATTERN_REGS];
  int                    cur_len;
  int                    cur_delta;
  int                    items_sent = 0;
  int                    idle_cycles = 0;
  bit                    calm = 1'b0;
  bit                    long_hold_req = 1'b0;

  delta_approximate_pattern_match u_dut (
    .clk          (clk),
    .rst          (rst),
    .text_valid   (text_valid),
    .text_stall   (text_stall),
    .text         (text),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Monitor: settings, text and results in order of transfer; idle watchdog
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_valid && cfg_ready) sb.write_reg(cfg_index, cfg_data);
      if (text_valid && !text_stall) sb.note_text(text);
      if (result_valid && !result_stall) sb.check_result(result);
      if ((cfg_valid && cfg_ready) || (text_valid && !text_stall) ||
          (result_valid && !result_stall)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // Receiver: runs of free flow, short stalls, long stalls, one forced long hold
  initial begin
    int n;
    int r;
    forever begin
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        result_stall <= 1'b1;
        n = LONG_HOLD;
      end else if (calm) begin
        result_stall <= 1'b0;
        n = 1;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 50) begin
          result_stall <= 1'b0;
          n = $urandom_range(1, 20);
        end else if (r < 90) begin
          result_stall <= 1'b1;
          n = $urandom_range(1, 3);
        end else begin
          result_stall <= 1'b1;
          n = $urandom_range(8, 30);
        end
      end
      repeat (n) @(posedge clk);
    end
  end

  // One text transfer, after a random gap unless the phase is calm
  task automatic send_text(input logic [7:0] b, input logic eot);
    int gap;
    int r;
    gap = 0;
    if (!calm) begin
      r = $urandom_range(0, 99);
      if (r >= 90) gap = $urandom_range(8, 25);
      else if (r >= 60) gap = $urandom_range(1, 3);
    end
    if (gap > 0) begin
      text_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    text_valid       <= 1'b1;
    text.text_byte   <= b;
    text.end_of_text <= eot;
    do @(posedge clk); while (text_stall);
    items_sent++;
  endtask

  // Leaves cfg_valid high; the caller drops it after the last write
  task automatic write_reg(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    case (idx)
      REG_PATTERN_LENGTH: cur_len = int'(value[LENGTH_BITS-1:0]);
      REG_MAX_DIFFERENCE: cur_delta = int'(value[DELTA_BITS-1:0]);
      default: cur_pattern[int'(idx)] = value;
    endcase
    do @(posedge clk); while (!cfg_ready);
  endtask

  // Stop offering text and wait until every predicted result has come back
  task automatic drain_results();
    text_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic run_directed();
    // reset settings: one-byte pattern 0x00, exact match only
    send_text(8'h00, 1'b0);
    send_text(8'hFF, 1'b0);
    send_text(8'h01, 1'b0);
    send_text(8'h00, 1'b1);   // match on the last byte of a text
    send_text(8'h00, 1'b0);   // position restarts at zero
    drain_results();
    // pattern FF 00 80 with delta 1; upper registers hold unused bytes
    write_reg(REG_PATTERN_0, 64'h0000_0000_0080_00FF);
    write_reg(REG_PATTERN_1, 64'hFFFF_FFFF_FFFF_FFFF);
    write_reg(REG_PATTERN_2, 64'h0123_4567_89AB_CDEF);
    write_reg(REG_PATTERN_3, 64'h8000_0000_0000_0001);
    write_reg(REG_PATTERN_LENGTH, 64'd3);
    write_reg(REG_MAX_DIFFERENCE, 64'd1);
    cfg_valid <= 1'b0;
    send_text(8'hFE, 1'b0);   // window kept across the settings change
    send_text(8'h01, 1'b0);
    send_text(8'h81, 1'b0);
    send_text(8'hFF, 1'b0);
    send_text(8'h02, 1'b0);   // off by two: no match
    send_text(8'h80, 1'b1);
    send_text(8'hFF, 1'b0);   // short text after the clear
    send_text(8'h00, 1'b0);
    drain_results();
    // zero length never matches
    write_reg(REG_PATTERN_LENGTH, 64'd0);
    cfg_valid <= 1'b0;
    send_text(8'h00, 1'b0);
    send_text(8'hFF, 1'b0);
    send_text(8'h80, 1'b1);
    drain_results();
  endtask

  task automatic run_random();
    int         phase;
    int         n;
    int         r;
    int         mode;
    int         eff_len;
    int         copy_pos;
    int         spoil_at;
    int         off;
    int         v;
    bit         alphabet;
    logic [7:0] pb;
    logic [7:0] b;
    logic       eot;
    logic [CFG_DATA_W-1:0] word;
    phase    = 0;
    alphabet = 1'b0;
    while (items_sent < TARGET_ITEMS) begin
      // pattern: random, all zero, all ones, or a four-letter alphabet
      if (phase < 2 || $urandom_range(0, 99) < 60) begin
        mode     = (phase == 1) ? 2 : $urandom_range(0, 3);
        alphabet = (mode == 3);
        for (int w = 0; w < PATTERN_REGS; w++) begin
          for (int k = 0; k < 8; k++) begin
            case (mode)
              0: word[k*8 +: 8] = 8'($urandom_range(0, 255));
              1: word[k*8 +: 8] = 8'h00;
              2: word[k*8 +: 8] = 8'hFF;
              default: word[k*8 +: 8] = 8'h30 + 8'($urandom_range(0, 3));
            endcase
          end
          write_reg(cfg_index_t'(w), word);
        end
      end
      // length and delta, with the extremes forced in the first phases
      case (phase)
        0: begin
          write_reg(REG_PATTERN_LENGTH, 64'd63);   // saturates to the window size
          write_reg(REG_MAX_DIFFERENCE, 64'd255);
        end
        1: begin
          write_reg(REG_PATTERN_LENGTH, 64'(WINDOW));
          write_reg(REG_MAX_DIFFERENCE, 64'd0);
        end
        2: begin
          write_reg(REG_PATTERN_LENGTH, 64'd4);
          write_reg(REG_MAX_DIFFERENCE, 64'd10);
        end
        default: begin
          r = $urandom_range(0, 99);
          if (r < 3) write_reg(REG_PATTERN_LENGTH, 64'd0);
          else if (r < 8) write_reg(REG_PATTERN_LENGTH, 64'($urandom_range(WINDOW + 1, 63)));
          else if (r < 15) write_reg(REG_PATTERN_LENGTH, 64'(WINDOW));
          else if (r < 30) write_reg(REG_PATTERN_LENGTH, 64'd1);
          else write_reg(REG_PATTERN_LENGTH, 64'($urandom_range(2, 12)));
          r = $urandom_range(0, 99);
          if (r < 20) write_reg(REG_MAX_DIFFERENCE, 64'd0);
          else if (r < 27) write_reg(REG_MAX_DIFFERENCE, 64'd255);
          else if (r < 70) write_reg(REG_MAX_DIFFERENCE, 64'($urandom_range(0, 8)));
          else write_reg(REG_MAX_DIFFERENCE, 64'($urandom_range(0, 255)));
        end
      endcase
      cfg_valid <= 1'b0;

      // phase 2 fills the block against a long receiver hold
      calm = (phase == 2) || ($urandom_range(0, 99) < 15);
      if (phase == 2) long_hold_req = 1'b1;
      n        = (phase == 2) ? 40 : $urandom_range(20, 90);
      eff_len  = (cur_len > WINDOW) ? WINDOW : cur_len;
      copy_pos = -1;
      spoil_at = -1;
      repeat (n) begin
        // planted copies of the pattern, perturbed within delta or spoiled at one byte, among random bytes
        if (copy_pos < 0 && eff_len > 0 && $urandom_range(0, 99) < 30) begin
          copy_pos = 0;
          spoil_at = ($urandom_range(0, 3) == 0) ? $urandom_range(0, eff_len - 1) : -1;
        end
        if (copy_pos >= 0) begin
          pb  = cur_pattern[copy_pos / 8][(copy_pos % 8) * 8 +: 8];
          off = (copy_pos == spoil_at) ? cur_delta + 1 + $urandom_range(0, 3)
                                       : $urandom_range(0, cur_delta);
          v   = int'(pb);
          v   = $urandom_range(0, 1) ? v + off : v - off;
          if (v < 0) v = 0;
          if (v > 255) v = 255;
          b = v[7:0];
          copy_pos++;
          if (copy_pos >= eff_len) copy_pos = -1;
        end else if (alphabet && $urandom_range(0, 1)) begin
          b = 8'h30 + 8'($urandom_range(0, 3));
        end else begin
          r = $urandom_range(0, 9);
          if (r == 0) b = 8'h00;
          else if (r == 1) b = 8'hFF;
          else b = 8'($urandom_range(0, 255));
        end
        eot = ($urandom_range(0, 59) == 0);
        if (eot) copy_pos = -1;
        send_text(b, eot);
      end
      // sender waits out every outstanding result before the next settings
      drain_results();
      phase++;
    end
  endtask

  initial begin
    rst          <= 1'b1;
    text_valid   <= 1'b0;
    text         <= '0;
    cfg_valid    <= 1'b0;
    cfg_index    <= REG_PATTERN_0;
    cfg_data     <= '0;
    sb = new();
    foreach (cur_pattern[i]) cur_pattern[i] = '0;
    cur_len   = LENGTH_RESET;
    cur_delta = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    run_directed();
    run_random();
    if (sb.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

FILE: delta_approximate_pattern_match.f
sv/dapm_pkg.sv
sv/delta_approximate_pattern_match.sv
tb/tb.sv
